@@ rtl/core/spg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

    localparam int CH_W   = 8;
    localparam int STK_W  = 4;
    localparam int IDX_W  = 16;
    localparam int FACT_W = 27;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_NEXT   = 2'd2;
    localparam logic [1:0] CMD_REWIND = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]  char_out;
        logic             is_last;
        logic [1:0]       status;
        logic [IDX_W-1:0] perm_index;
        logic [IDX_W-1:0] perm_total;
    } spg_result_t;

    typedef struct packed {
        logic        valid;
        spg_result_t data;
    } spg_push_t;

endpackage

`default_nettype wire

@@ rtl/core/spg_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spg_cmd_if import spg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      command;
    logic [CH_W-1:0] char_in;

    modport source (output valid, command, char_in, input ready);
    modport sink   (input valid, command, char_in, output ready);
endinterface

interface spg_res_if import spg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  char_out;
    logic             is_last;
    logic [1:0]       status;
    logic [IDX_W-1:0] perm_index;
    logic [IDX_W-1:0] perm_total;

    modport source (output valid, char_out, is_last, status, perm_index, perm_total,
                    input ready);
    modport sink   (input valid, char_out, is_last, status, perm_index, perm_total,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/spg_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spg_seq
    import spg_pkg::*;
#(
    parameter int MAX_LEN = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spg_cmd_if.sink    cmd,
    output spg_push_t  push,
    input  wire logic  free
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RESP   = 4'd1;
    localparam logic [3:0] S_UN_RD  = 4'd2;
    localparam logic [3:0] S_UN_SW  = 4'd3;
    localparam logic [3:0] S_SW_RD  = 4'd4;
    localparam logic [3:0] S_SW_W1  = 4'd5;
    localparam logic [3:0] S_SW_W2  = 4'd6;
    localparam logic [3:0] S_DESC   = 4'd7;
    localparam logic [3:0] S_AD_CHK = 4'd8;
    localparam logic [3:0] S_AD_RS  = 4'd9;
    localparam logic [3:0] S_AD_INC = 4'd10;
    localparam logic [3:0] S_EM_RD  = 4'd11;
    localparam logic [3:0] S_EM_OUT = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [CH_W-1:0]   char_reg, char_next;
    logic [1:0]        status_reg, status_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     depth_reg, depth_next;
    logic [FACT_W-1:0] fact_reg, fact_next;
    logic [FACT_W-1:0] emit_reg, emit_next;
    logic              started_reg, started_next;
    logic              done_reg, done_next;
    logic [IW-1:0]     swa_reg, swa_next;
    logic [IW-1:0]     swb_reg, swb_next;
    logic [STK_W-1:0]  i_reg, i_next;
    logic [IW-1:0]     m_reg, m_next;
    logic [IW-1:0]     p_reg, p_next;

    logic [CH_W-1:0]   work_mem [MAX_LEN];
    logic [CH_W-1:0]   wrd0_reg, wrd1_reg;
    logic [STK_W-1:0]  stk_mem [MAX_LEN];
    logic [STK_W-1:0]  srd_reg;

    logic              w_we, w_re, s_we, s_re;
    logic [IW-1:0]     w_waddr, w_raddr0, w_raddr1, s_waddr, s_raddr;
    logic [CH_W-1:0]   w_wdata;
    logic [STK_W-1:0]  s_wdata;

    logic [IW-1:0]     depth_dec;
    logic [CW-1:0]     count_inc;
    logic [FACT_W-1:0] fact_base;
    logic [FACT_W-1:0] fact_mul;
    logic [STK_W-1:0]  i_inc;
    logic              p_last;

    assign depth_dec = depth_reg - IW'(1);
    assign count_inc = count_reg + CW'(1);
    assign fact_base = (fact_reg == '0) ? FACT_W'(1) : fact_reg;
    assign fact_mul  = fact_base * FACT_W'(count_inc);
    assign i_inc     = i_reg + STK_W'(1);
    assign p_last    = ((CW'(p_reg) + CW'(1)) == count_reg);

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd_next     = cmd_reg;
        char_next    = char_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        depth_next   = depth_reg;
        fact_next    = fact_reg;
        emit_next    = emit_reg;
        started_next = started_reg;
        done_next    = done_reg;
        swa_next     = swa_reg;
        swb_next     = swb_reg;
        i_next       = i_reg;
        m_next       = m_reg;
        p_next       = p_reg;
        w_we         = 1'b0;
        w_waddr      = swa_reg;
        w_wdata      = wrd1_reg;
        w_re         = 1'b0;
        w_raddr0     = swa_reg;
        w_raddr1     = swb_reg;
        s_we         = 1'b0;
        s_waddr      = m_reg;
        s_wdata      = STK_W'(m_reg);
        s_re         = 1'b0;
        s_raddr      = depth_dec;
        push         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next  = cmd.command;
                    char_next = cmd.char_in;
                    unique case (cmd.command) inside
                        CMD_CLEAR, CMD_REWIND:
                        begin
                            state_next = S_UN_RD;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CW'(MAX_LEN))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_UN_RD;
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else if (done_reg)
                            begin
                                status_next = ST_DONE;
                                state_next  = S_RESP;
                            end
                            else if (!started_reg)
                            begin
                                started_next = 1'b1;
                                m_next       = '0;
                                state_next   = S_DESC;
                            end
                            else
                            begin
                                state_next = S_AD_CHK;
                            end
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (free)
                begin
                    push.valid            = 1'b1;
                    push.data.char_out    = '0;
                    push.data.is_last     = 1'b1;
                    push.data.status      = status_reg;
                    push.data.perm_index  = '0;
                    push.data.perm_total  = fact_reg[IDX_W-1:0];
                    state_next            = S_IDLE;
                end
            end
            S_UN_RD:
            begin
                if (depth_reg == '0)
                begin
                    started_next = 1'b0;
                    done_next    = 1'b0;
                    emit_next    = '0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        count_next = '0;
                        fact_next  = '0;
                    end
                    else if (cmd_reg == CMD_APPEND)
                    begin
                        w_we       = 1'b1;
                        w_waddr    = count_reg[IW-1:0];
                        w_wdata    = char_reg;
                        count_next = count_inc;
                        fact_next  = fact_mul;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    s_re       = 1'b1;
                    state_next = S_UN_SW;
                end
            end
            S_UN_SW:
            begin
                swa_next   = depth_dec;
                swb_next   = srd_reg[IW-1:0];
                depth_next = depth_dec;
                ret_next   = S_UN_RD;
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                w_re       = 1'b1;
                state_next = S_SW_W1;
            end
            S_SW_W1:
            begin
                w_we       = 1'b1;
                w_waddr    = swa_reg;
                w_wdata    = wrd1_reg;
                state_next = S_SW_W2;
            end
            S_SW_W2:
            begin
                w_we       = 1'b1;
                w_waddr    = swb_reg;
                w_wdata    = wrd0_reg;
                state_next = ret_reg;
            end
            S_DESC:
            begin
                if ((CW'(m_reg) + CW'(1)) < count_reg)
                begin
                    s_we    = 1'b1;
                    s_waddr = m_reg;
                    s_wdata = STK_W'(m_reg);
                    m_next  = m_reg + IW'(1);
                end
                else
                begin
                    depth_next = IW'(count_reg - CW'(1));
                    p_next     = '0;
                    state_next = S_EM_RD;
                end
            end
            S_AD_CHK:
            begin
                if (depth_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                end
                else
                begin
                    s_re       = 1'b1;
                    depth_next = depth_dec;
                    state_next = S_AD_RS;
                end
            end
            S_AD_RS:
            begin
                i_next     = srd_reg;
                swa_next   = depth_reg;
                swb_next   = srd_reg[IW-1:0];
                ret_next   = S_AD_INC;
                state_next = S_SW_RD;
            end
            S_AD_INC:
            begin
                if (i_inc < STK_W'(count_reg))
                begin
                    s_we       = 1'b1;
                    s_waddr    = depth_reg;
                    s_wdata    = i_inc;
                    swa_next   = depth_reg;
                    swb_next   = i_inc[IW-1:0];
                    m_next     = depth_reg + IW'(1);
                    ret_next   = S_DESC;
                    state_next = S_SW_RD;
                end
                else
                begin
                    state_next = S_AD_CHK;
                end
            end
            S_EM_RD:
            begin
                w_re       = 1'b1;
                w_raddr0   = p_reg;
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (free)
                begin
                    push.valid            = 1'b1;
                    push.data.char_out    = wrd0_reg;
                    push.data.is_last     = p_last;
                    push.data.status      = ST_OK;
                    push.data.perm_index  = emit_reg[IDX_W-1:0];
                    push.data.perm_total  = fact_reg[IDX_W-1:0];
                    if (p_last)
                    begin
                        emit_next  = emit_reg + FACT_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + IW'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            cmd_reg     <= CMD_CLEAR;
            status_reg  <= ST_OK;
            count_reg   <= '0;
            depth_reg   <= '0;
            fact_reg    <= '0;
            emit_reg    <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            swa_reg     <= '0;
            swb_reg     <= '0;
            i_reg       <= '0;
            m_reg       <= '0;
            p_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cmd_reg     <= cmd_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
            depth_reg   <= depth_next;
            fact_reg    <= fact_next;
            emit_reg    <= emit_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            swa_reg     <= swa_next;
            swb_reg     <= swb_next;
            i_reg       <= i_next;
            m_reg       <= m_next;
            p_reg       <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    // character store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            work_mem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            wrd0_reg <= work_mem[w_raddr0];
            wrd1_reg <= work_mem[w_raddr1];
        end
    end

    // loop stack: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stk_mem[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            srd_reg <= stk_mem[s_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/spg_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spg_out_stage
    import spg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire spg_push_t push,
    output logic           free,
    spg_res_if.source      res
);

    logic        valid_reg;
    spg_result_t data_reg;

    assign free            = !valid_reg || res.ready;
    assign res.valid       = valid_reg;
    assign res.char_out    = data_reg.char_out;
    assign res.is_last     = data_reg.is_last;
    assign res.status      = data_reg.status;
    assign res.perm_index  = data_reg.perm_index;
    assign res.perm_total  = data_reg.perm_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            data_reg <= push.data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/swap_permutation_generator.sv @@
// channel   dir  payload                                               role
// cmd       in   command, char_in                                      clear/append/next/rewind
// res       out  char_out, is_last, status, perm_index, perm_total     one char per item
//
// One command item at a time; cmd.ready is high only while the sequencer is idle.
// Next: pops stack levels, undoing the swap at each, swaps in the next choice, pushes descended levels,
// then emits the characters one by one out of the character store, one item per character.
// Clear/append/rewind: first undo the swap of every pending stack level, then update the store.
// A registered output stage holds a result while res.ready is low; it stalls the sequencer.
// Reset is asynchronous, active low, and clears all control state; stores need none.
`timescale 1ns / 1ps
`default_nettype none

module swap_permutation_generator
    import spg_pkg::*;
#(
    parameter int MAX_LEN = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spg_cmd_if.sink    cmd,
    spg_res_if.source  res
);

    spg_push_t push;
    logic      free;

    spg_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .push  (push),
        .free  (free)
    );

    spg_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .free  (free),
        .res   (res)
    );

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> free)
        else $error("result pushed into a full output stage");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !push.valid)
        else $error("result pushed while the sequencer is idle");

    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.data.status != ST_OK) |->
        (push.data.is_last && push.data.char_out == '0 && push.data.perm_index == '0))
        else $error("status item with bad payload");
`endif

endmodule

`default_nettype wire
